FILE: sv/command_byte_decimal_parser_macros.svh
// assertion macros for the command byte decimal parser
`ifndef COMMAND_BYTE_DECIMAL_PARSER_MACROS_SVH
`define COMMAND_BYTE_DECIMAL_PARSER_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define CBDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbdp check failed");

// next-cycle implication, checked on clk outside reset
`define CBDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbdp check failed");

`endif

FILE: sv/cbdp_pkg.sv
// shared types and constants for the command byte decimal parser
`default_nettype none

package cbdp_pkg;

  localparam int MAX_CHARS_DEF = 20;
  localparam int MANT_W        = 60;
  localparam int FRAC_W        = 5;
  localparam int BYTE_W        = 8;
  localparam int PROD_W        = MANT_W + 4;

  localparam logic [MANT_W-1:0] MANT_MAX = 60'd999999999999999999;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd18;

  localparam logic [BYTE_W-1:0] CH_DOLLAR   = 8'h24;
  localparam logic [BYTE_W-1:0] CH_POINT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_ONE      = 8'h31;
  localparam logic [BYTE_W-1:0] CH_TWO      = 8'h32;
  localparam logic [BYTE_W-1:0] CH_THREE    = 8'h33;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DUTY0 = 3'd1,
    PH_DUTY1 = 3'd2,
    PH_GAINP = 3'd3,
    PH_GAINI = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MODE = 2'd0,
    KIND_DUTY = 2'd1,
    KIND_GAIN = 2'd2
  } kind_t;

  // gain string state apart from the character count
  typedef struct packed {
    logic [MANT_W-1:0] acc;
    logic [FRAC_W-1:0] frac;
    logic              point;
    logic              ovf;
  } str_t;

endpackage

`default_nettype wire

FILE: sv/command_byte_decimal_parser.sv
// command byte decimal parser top level: phase control and result register
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   in_rx_byte
//  out_     output     out_valid / out_ready kind, mode, duty, gain fields
//
// one byte per cycle; each byte is parsed in the cycle it is accepted and
// its result, if any, appears in the result register on the next cycle.
// the result register sets the rate: a new byte is taken whenever the
// register is empty or its result is transferred in the same cycle.
// synchronous active-low reset returns to idle with the gain string cleared.
// a stall on out_ready holds the result and stops input only while it waits.
`default_nettype none
`include "command_byte_decimal_parser_macros.svh"

module command_byte_decimal_parser
  import cbdp_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_result_kind,
  output logic                   out_mode_sel,
  output logic [BYTE_W-1:0]      out_duty_value,
  output logic                   out_gain_select,
  output logic [MANT_W-1:0]      out_gain_mantissa,
  output logic [FRAC_W-1:0]      out_frac_digits,
  output logic                   out_overlong
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  phase_t             phase_r, phase_nxt;
  str_t               str_r, str_nxt, str_chr;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_chr;

  logic               out_vld_r, out_vld_nxt;
  kind_t              kind_r, kind_nxt;
  logic               mode_r, mode_nxt;
  logic [BYTE_W-1:0]  duty_r, duty_nxt;
  logic               gsel_r, gsel_nxt;
  logic [MANT_W-1:0]  mant_r, mant_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic               ovl_r, ovl_nxt;

  logic               in_fire;
  logic               res_vld;

  assign in_ready = !out_vld_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  cbdp_digit_acc #(
    .MAX_CHARS (MAX_CHARS),
    .CNT_W     (CNT_W)
  ) u_digit_acc (
    .ch      (in_rx_byte),
    .str_cur (str_r),
    .cnt_cur (cnt_r),
    .str_upd (str_chr),
    .cnt_upd (cnt_chr)
  );

  always_comb begin
    phase_nxt = phase_r;
    str_nxt   = str_r;
    cnt_nxt   = cnt_r;
    res_vld   = 1'b0;
    kind_nxt  = KIND_MODE;
    mode_nxt  = 1'b0;
    duty_nxt  = '0;
    gsel_nxt  = 1'b0;
    mant_nxt  = '0;
    frac_nxt  = '0;
    ovl_nxt   = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_DUTY0, PH_DUTY1: begin
          res_vld   = 1'b1;
          kind_nxt  = KIND_DUTY;
          mode_nxt  = (phase_r == PH_DUTY1);
          duty_nxt  = in_rx_byte;
          phase_nxt = PH_IDLE;
        end
        PH_GAINP, PH_GAINI: begin
          if (in_rx_byte == CH_DOLLAR) begin
            res_vld   = 1'b1;
            kind_nxt  = KIND_GAIN;
            gsel_nxt  = (phase_r == PH_GAINI);
            mant_nxt  = str_r.acc;
            frac_nxt  = str_r.frac;
            ovl_nxt   = str_r.ovf;
            str_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_IDLE;
          end else begin
            str_nxt = str_chr;
            cnt_nxt = cnt_chr;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if ((in_rx_byte == CH_ZERO) || (in_rx_byte == CH_ONE)) begin
            res_vld   = 1'b1;
            kind_nxt  = KIND_MODE;
            mode_nxt  = (in_rx_byte == CH_ONE);
            phase_nxt = (in_rx_byte == CH_ONE) ? PH_DUTY1 : PH_DUTY0;
          end else if ((in_rx_byte == CH_TWO) || (in_rx_byte == CH_THREE)) begin
            str_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = (in_rx_byte == CH_THREE) ? PH_GAINI : PH_GAINP;
          end
        end
      endcase
    end
    out_vld_nxt = in_ready ? res_vld : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      str_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      str_r     <= str_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload, loaded on each parsed byte that gives a result
  always_ff @(posedge clk) begin
    if (in_fire && res_vld) begin
      kind_r <= kind_nxt;
      mode_r <= mode_nxt;
      duty_r <= duty_nxt;
      gsel_r <= gsel_nxt;
      mant_r <= mant_nxt;
      frac_r <= frac_nxt;
      ovl_r  <= ovl_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_result_kind   = kind_r;
  assign out_mode_sel      = mode_r;
  assign out_duty_value    = duty_r;
  assign out_gain_select   = gsel_r;
  assign out_gain_mantissa = mant_r;
  assign out_frac_digits   = frac_r;
  assign out_overlong      = ovl_r;

  // outside a gain string the string state is always clear
  `CBDP_ASSERT_NOW(a_str_clear_outside_gain, (phase_r == PH_IDLE) || (phase_r == PH_DUTY0) || (phase_r == PH_DUTY1), (str_r == '0) && (cnt_r == '0))
  `CBDP_ASSERT_NOW(a_mant_in_range, 1'b1, str_r.acc <= MANT_MAX)
  `CBDP_ASSERT_NOW(a_frac_in_range, 1'b1, (str_r.frac <= FRAC_MAX) && (cnt_r <= CNT_W'(MAX_CHARS)))
  // a duty byte always yields a duty result on the next cycle
  `CBDP_ASSERT_NEXT(a_duty_result, in_fire && ((phase_r == PH_DUTY0) || (phase_r == PH_DUTY1)), out_vld_r && (kind_r == KIND_DUTY) && (phase_r == PH_IDLE))

endmodule

`default_nettype wire

FILE: sv/cbdp_digit_acc.sv
// one gain string character: point, fraction count and saturating decimal accumulate
`default_nettype none

module cbdp_digit_acc
  import cbdp_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  parameter int CNT_W     = $clog2(MAX_CHARS + 1)
) (
  input  wire logic [BYTE_W-1:0] ch,
  input  wire str_t              str_cur,
  input  wire logic [CNT_W-1:0]  cnt_cur,
  output str_t                   str_upd,
  output logic [CNT_W-1:0]       cnt_upd
);

  logic [PROD_W-1:0] acc_ext;
  logic [PROD_W-1:0] prod;
  logic [3:0]        nib;

  assign nib     = 4'(ch & NIBBLE_MASK);
  assign acc_ext = {{(PROD_W-MANT_W){1'b0}}, str_cur.acc};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{(PROD_W-4){1'b0}}, nib};

  always_comb begin
    str_upd = str_cur;
    cnt_upd = cnt_cur;
    if (cnt_cur >= CNT_W'(MAX_CHARS)) begin
      str_upd.ovf = 1'b1;
    end else begin
      cnt_upd = cnt_cur + CNT_W'(1);
      if (ch == CH_POINT) begin
        str_upd.point = 1'b1;
        str_upd.frac  = '0;
      end else if (str_cur.point && (str_cur.frac >= FRAC_MAX)) begin
        str_upd.ovf = 1'b1;
      end else begin
        if (str_cur.point) begin
          str_upd.frac = str_cur.frac + FRAC_W'(1);
        end
        if (prod > {{(PROD_W-MANT_W){1'b0}}, MANT_MAX}) begin
          str_upd.acc = MANT_MAX;
          str_upd.ovf = 1'b1;
        end else begin
          str_upd.acc = prod[MANT_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire
